// ===== src/mpv_pkg.sv =====
package mpv_pkg;

    localparam int unsigned MaxTreeDepth = 64;
    localparam logic [6:0] CountMax = 7'd127;

    typedef enum logic [1:0] {
        REQ_START   = 2'd0,
        REQ_SIBLING = 2'd1,
        REQ_CHECK   = 2'd2,
        REQ_RSVD    = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_MATCH    = 2'd0,
        ST_MISMATCH = 2'd1,
        ST_LENGTH   = 2'd2,
        ST_NO_PROOF = 2'd3
    } t_status;

    typedef enum logic {
        CFG_TREE_DEPTH   = 1'b0,
        CFG_LENGTH_CHECK = 1'b1
    } t_cfg_idx;

    // classified command handed from front to back
    typedef struct packed {
        t_req        req;
        logic [63:0] hash_word_0;
        logic [63:0] hash_word_1;
        logic [63:0] hash_word_2;
        logic [63:0] hash_word_3;
        logic [63:0] leaf_position;
    } t_cmd;

    localparam logic [31:0] KInit [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] KRound [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage

// ===== src/mpv_if.sv =====
interface mpv_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [63:0] hash_word_0;
    logic [63:0] hash_word_1;
    logic [63:0] hash_word_2;
    logic [63:0] hash_word_3;
    logic [63:0] leaf_position;
    modport source (output valid, req_type, hash_word_0, hash_word_1, hash_word_2,
                    hash_word_3, leaf_position, input ready);
    modport sink (input valid, req_type, hash_word_0, hash_word_1, hash_word_2,
                  hash_word_3, leaf_position, output ready);
endinterface

interface mpv_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [63:0] root_word_0;
    logic [63:0] root_word_1;
    logic [63:0] root_word_2;
    logic [63:0] root_word_3;
    modport source (output valid, status, root_word_0, root_word_1, root_word_2,
                    root_word_3, input ready);
    modport sink (input valid, status, root_word_0, root_word_1, root_word_2,
                  root_word_3, output ready);
endinterface

interface mpv_cfg_if;
    logic        valid;
    logic        ready;
    logic        index;
    logic [6:0]  data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== src/mpv_cmd_fifo.sv =====
module mpv_cmd_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  mpv_pkg::t_cmd  i_data,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output mpv_pkg::t_cmd  o_data
);
    import mpv_pkg::*;

    // two-entry queue between classifier and hash engine
    t_cmd       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push) else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop) else $error("pop from empty queue");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count out of range");
`endif
endmodule

// ===== src/mpv_sha_core.sv =====
module mpv_sha_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [511:0] i_block,
    output logic         o_busy,
    output logic         o_done,
    output logic [255:0] o_digest
);
    import mpv_pkg::*;

    // two compressions of 64 rounds each, one round per cycle, each closed by a feed-forward add
    typedef enum logic [1:0] {S_IDLE, S_ROUND, S_ADD} t_state;

    t_state      r_state;
    logic [5:0]  r_rnd;
    logic        r_blk2;
    logic [31:0] r_w [16];
    logic [31:0] r_v [8];
    logic [31:0] r_h [8];
    logic        r_done;

    logic [31:0] s0, s1, wn, bs1, bs0, ch, mj, t1, t2, wcur;

    always_comb begin
        wcur = r_w[0];
        s0   = rotr(r_w[1], 7) ^ rotr(r_w[1], 18) ^ (r_w[1] >> 3);
        s1   = rotr(r_w[14], 17) ^ rotr(r_w[14], 19) ^ (r_w[14] >> 10);
        wn   = r_w[0] + s0 + r_w[9] + s1;
        bs1  = rotr(r_v[4], 6) ^ rotr(r_v[4], 11) ^ rotr(r_v[4], 25);
        ch   = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        t1   = r_v[7] + bs1 + ch + KRound[r_rnd] + wcur;
        bs0  = rotr(r_v[0], 2) ^ rotr(r_v[0], 13) ^ rotr(r_v[0], 22);
        mj   = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        t2   = bs0 + mj;
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;
    always_comb begin
        for (int i = 0; i < 8; i++) o_digest[255 - 32*i -: 32] = r_h[i];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_rnd   <= 6'd0;
            r_blk2  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        for (int i = 0; i < 16; i++) r_w[i] <= i_block[511 - 32*i -: 32];
                        for (int i = 0; i < 8; i++) begin
                            r_v[i] <= KInit[i];
                            r_h[i] <= KInit[i];
                        end
                        r_rnd   <= 6'd0;
                        r_blk2  <= 1'b0;
                        r_state <= S_ROUND;
                    end
                end
                S_ROUND: begin
                    for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
                    r_w[15] <= wn;
                    r_v[7] <= r_v[6]; r_v[6] <= r_v[5]; r_v[5] <= r_v[4];
                    r_v[4] <= r_v[3] + t1;
                    r_v[3] <= r_v[2]; r_v[2] <= r_v[1]; r_v[1] <= r_v[0];
                    r_v[0] <= t1 + t2;
                    r_rnd <= r_rnd + 6'd1;
                    if (r_rnd == 6'd63) r_state <= S_ADD;
                end
                S_ADD: begin
                    for (int i = 0; i < 8; i++) begin
                        r_h[i] <= r_h[i] + r_v[i];
                        r_v[i] <= r_h[i] + r_v[i];
                    end
                    if (r_blk2) begin
                        r_state <= S_IDLE;
                        r_done  <= 1'b1;
                    end else begin
                        // padding block for a 64-byte message
                        r_w[0]  <= 32'h80000000;
                        for (int i = 1; i < 15; i++) r_w[i] <= 32'd0;
                        r_w[15] <= 32'd512;
                        r_blk2  <= 1'b1;
                        r_state <= S_ROUND;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_done_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done) else $error("done held two cycles");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> r_state == S_IDLE) else $error("done while busy");
    a_rnd_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_busy) |-> r_rnd == 6'd0) else $error("round count not cleared");
`endif
endmodule

// ===== src/mpv_back.sv =====
module mpv_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_empty,
    input  mpv_pkg::t_cmd  i_cmd,
    output logic           o_pop,
    input  logic [6:0]     i_tree_depth,
    input  logic           i_length_check,
    mpv_rsp_if.source      rsp
);
    import mpv_pkg::*;

    typedef enum logic [1:0] {B_IDLE, B_HASH, B_WAIT} t_state;

    t_state       r_state;
    logic [255:0] r_hash;
    logic [63:0]  r_pos;
    logic [6:0]   r_cnt;
    logic         r_open;
    logic         r_ovalid;
    logic [1:0]   r_ostatus;
    logic [255:0] r_oroot;

    logic         sha_start, sha_busy, sha_done;
    logic [255:0] sha_dig, cmd_hash;
    logic [511:0] blk;
    logic [6:0]   depth;
    logic         out_free;
    logic         chk_fire;

    assign cmd_hash = {i_cmd.hash_word_0, i_cmd.hash_word_1,
                       i_cmd.hash_word_2, i_cmd.hash_word_3};
    assign blk = r_pos[0] ? {cmd_hash, r_hash} : {r_hash, cmd_hash};
    assign depth = (i_tree_depth > 7'(MaxTreeDepth)) ? 7'(MaxTreeDepth) : i_tree_depth;
    assign out_free = !r_ovalid || rsp.ready;
    // a check leaves the queue and loads the result register
    assign chk_fire = (r_state == B_IDLE) && !i_empty && (i_cmd.req == REQ_CHECK) && out_free;

    // open sibling pops on digest, check on free output, rest at once
    always_comb begin
        o_pop = 1'b0;
        sha_start = 1'b0;
        if (r_state == B_IDLE && !i_empty) begin
            case (i_cmd.req)
                REQ_SIBLING: sha_start = r_open;
                REQ_CHECK:   o_pop = out_free;
                default:     o_pop = 1'b1;
            endcase
            if (i_cmd.req == REQ_SIBLING && !r_open) o_pop = 1'b1;
        end
        if (r_state == B_WAIT && sha_done) o_pop = 1'b1;
    end

    mpv_sha_core u_sha (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (sha_start),
        .i_block  (blk),
        .o_busy   (sha_busy),
        .o_done   (sha_done),
        .o_digest (sha_dig)
    );

    assign rsp.valid       = r_ovalid;
    assign rsp.status      = r_ostatus;
    assign rsp.root_word_0 = r_oroot[255:192];
    assign rsp.root_word_1 = r_oroot[191:128];
    assign rsp.root_word_2 = r_oroot[127:64];
    assign rsp.root_word_3 = r_oroot[63:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_hash   <= '0;
            r_pos    <= '0;
            r_cnt    <= '0;
            r_open   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (chk_fire) r_ovalid <= 1'b1;
            else if (rsp.ready) r_ovalid <= 1'b0;
            unique case (r_state)
                B_IDLE: begin
                    if (!i_empty) begin
                        case (i_cmd.req)
                            REQ_START: begin
                                r_hash <= cmd_hash;
                                r_pos  <= i_cmd.leaf_position;
                                r_cnt  <= '0;
                                r_open <= 1'b1;
                            end
                            REQ_SIBLING: if (r_open) r_state <= B_HASH;
                            REQ_CHECK: if (out_free) begin
                                r_open   <= 1'b0;
                                if (!r_open) begin
                                    r_ostatus <= ST_NO_PROOF;
                                    r_oroot   <= '0;
                                end else begin
                                    r_oroot <= r_hash;
                                    if (i_length_check && r_cnt != depth)
                                        r_ostatus <= ST_LENGTH;
                                    else if (r_hash == cmd_hash)
                                        r_ostatus <= ST_MATCH;
                                    else
                                        r_ostatus <= ST_MISMATCH;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                B_HASH: r_state <= B_WAIT;
                B_WAIT: begin
                    if (sha_done) begin
                        r_hash  <= sha_dig;
                        r_pos   <= r_pos >> 1;
                        if (r_cnt != CountMax) r_cnt <= r_cnt + 7'd1;
                        r_state <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_wait_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == B_HASH |-> sha_busy) else $error("engine not running");
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sha_done |-> r_state == B_WAIT) else $error("unexpected digest");
    a_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> !r_open) else $error("proof left open after check");
`endif
endmodule

// ===== src/mpv_front.sv =====
module mpv_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    mpv_req_if.sink        req,
    mpv_cfg_if.sink        cfg,
    input  logic           i_full,
    output logic           o_push,
    output mpv_pkg::t_cmd  o_cmd,
    output logic [6:0]     o_tree_depth,
    output logic           o_length_check
);
    import mpv_pkg::*;

    logic [6:0] r_depth;
    logic       r_lchk;

    // reserved codes are dropped here and never reach the queue
    assign req.ready = !i_full;
    assign o_push = req.valid && !i_full && (t_req'(req.req_type) != REQ_RSVD);
    assign o_cmd.req           = t_req'(req.req_type);
    assign o_cmd.hash_word_0   = req.hash_word_0;
    assign o_cmd.hash_word_1   = req.hash_word_1;
    assign o_cmd.hash_word_2   = req.hash_word_2;
    assign o_cmd.hash_word_3   = req.hash_word_3;
    assign o_cmd.leaf_position = req.leaf_position;

    assign cfg.ready      = 1'b1;
    assign o_tree_depth   = r_depth;
    assign o_length_check = r_lchk;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= 7'd32;
            r_lchk  <= 1'b1;
        end else if (cfg.valid) begin
            unique case (t_cfg_idx'(cfg.index))
                CFG_TREE_DEPTH:   r_depth <= cfg.data;
                CFG_LENGTH_CHECK: r_lchk  <= cfg.data[0];
                default: ;
            endcase
        end
    end
endmodule

// ===== src/merkle_proof_verifier_core.sv =====
// merkle path verifier, sha-256
// channels: req (sink) takes start, sibling and check words; rsp (source)
// gives status and computed root for each check; cfg writes index 0 tree
// depth and index 1 length check, always ready
// the front stage classifies each word and pushes it into a two-entry queue,
// dropping reserved request codes; the back stage drains the queue
// a start is handled by the back stage as it is popped; a sibling holds the
// back stage until the one-round-per-cycle sha-256 engine, running two
// 64-round compressions, returns its digest; a check passes the queue and the
// result register; starts and checks one per cycle while no sibling is hashing
// reset: depth 32, length check on, no proof open, queue and output empty
// a stalled receiver holds the result register; the back stage then holds
// a later check in the queue and the front stops accepting once it fills
module merkle_proof_verifier_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mpv_req_if.sink    req,
    mpv_rsp_if.source  rsp,
    mpv_cfg_if.sink    cfg
);
    import mpv_pkg::*;

    logic       push, pop, full, empty;
    t_cmd       cmd_in, cmd_out;
    logic [6:0] tree_depth;
    logic       length_check;

    mpv_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .req            (req),
        .cfg            (cfg),
        .i_full         (full),
        .o_push         (push),
        .o_cmd          (cmd_in),
        .o_tree_depth   (tree_depth),
        .o_length_check (length_check)
    );

    mpv_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (cmd_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (cmd_out)
    );

    mpv_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_empty        (empty),
        .i_cmd          (cmd_out),
        .o_pop          (pop),
        .i_tree_depth   (tree_depth),
        .i_length_check (length_check),
        .rsp            (rsp)
    );
endmodule
